// ----- rtl/hse_pkg.sv -----
// Package: grid constants, widths and shared types for the stencil energy block.
`default_nettype none
package hse_pkg;
  localparam int GRID_SIZE = 64;
  localparam int CW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int PSI_W = 24;
  localparam int POT_W = 24;
  localparam int COEF_W = 32;
  localparam int AREA_W = 24;
  localparam int HPSI_W = 32;
  localparam int EN_W = 48;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT} st_t;

  typedef struct packed {
    logic              valid;
    logic              interior;
    logic              last;
  } ctl_t;
endpackage
`default_nettype wire

// ----- rtl/hse_if.sv -----
// Interfaces: input sample channel and result channel.
`default_nettype none
interface hse_in_if;
  logic valid;
  logic ready;
  logic signed [hse_pkg::PSI_W-1:0] psi_sample;
  logic [hse_pkg::POT_W-1:0] potential_value;
  modport source (output valid, psi_sample, potential_value, input ready);
  modport sink (input valid, psi_sample, potential_value, output ready);
endinterface

interface hse_out_if;
  logic valid;
  logic ready;
  logic signed [hse_pkg::HPSI_W-1:0] hpsi_value;
  logic frame_last;
  logic signed [hse_pkg::EN_W-1:0] energy_total;
  modport source (output valid, hpsi_value, frame_last, energy_total, input ready);
  modport sink (input valid, hpsi_value, frame_last, energy_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/hamiltonian_stencil_energy.sv -----
// Top level: five-point Hamiltonian stencil with frame energy over a streamed grid.
// channel | dir | payload
// in_     | in  | psi_sample s24 Q2.22, potential_value u24 Q4.20
// out_    | out | hpsi_value s32 Q10.22, frame_last, energy_total s48 Q26.22
// cfg_    | in  | index 2b, data 32b, write enable
// A row-0 item steps through accept, buffer read and write-back.
// Other items hold ready low until their result is taken, so no new item is
// accepted while a result is still in flight or waiting for the sink.
// Synchronous active-low reset clears counters and accumulator; line buffers are
// not cleared (their unwritten contents reach only border points).
`default_nettype none
module hamiltonian_stencil_energy (
  input  wire logic clk,
  input  wire logic rst_n,
  hse_in_if.sink   in_ch,
  hse_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [hse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hse_pkg::COEF_W-1:0] cfg_data
);
  hse_pkg::st_t st_r, st_nxt;
  logic [hse_pkg::CW-1:0] col_r, col_nxt;
  logic [hse_pkg::CW-1:0] row_r, row_nxt;
  logic signed [hse_pkg::COEF_W-1:0] kr_r, kc_r;
  logic [hse_pkg::AREA_W-1:0] area_r;
  logic signed [hse_pkg::PSI_W-1:0] down_r, left_r, rctr_r;
  logic [hse_pkg::POT_W-1:0] pot_in_r;
  logic signed [hse_pkg::PSI_W-1:0] rd_up, rd_ctr, rd_next;
  logic [hse_pkg::POT_W-1:0] rd_pot;
  logic acc, step, done, rd_en, wr_en, out_busy_r;
  logic [hse_pkg::CW-1:0] rd_addr, col_p1;
  hse_pkg::ctl_t ctl;
  logic signed [hse_pkg::HPSI_W-1:0] hpsi;
  logic lst;
  logic signed [hse_pkg::EN_W-1:0] en;
  logic signed [hse_pkg::PSI_W-1:0] right;

  // right neighbor comes from a copy of the center row read at col+1
  hse_linebuf u_buf (
    .clk, .rd_en, .rd_addr, .wr_en, .wr_addr(col_r),
    .wr_up(rctr_r), .wr_ctr(down_r), .wr_pot(pot_in_r),
    .rd_up, .rd_ctr, .rd_pot
  );

  logic [hse_pkg::PSI_W-1:0] nxt_mem [hse_pkg::GRID_SIZE];
  always_ff @(posedge clk) begin
    if (wr_en) nxt_mem[col_r] <= down_r;
    if (rd_en) rd_next <= nxt_mem[col_p1];
  end

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == hse_pkg::S_IDLE) && !out_busy_r;
  assign col_p1 = (col_r == hse_pkg::CW'(hse_pkg::GRID_SIZE - 1)) ? '0 : col_r + 1'b1;
  assign rd_addr = col_r;
  assign right = (col_r == hse_pkg::CW'(hse_pkg::GRID_SIZE - 1)) ? '0 : rd_next;

  always_comb begin
    st_nxt = st_r;
    rd_en = 1'b0;
    wr_en = 1'b0;
    step = 1'b0;
    col_nxt = col_r;
    row_nxt = row_r;
    ctl.valid = (row_r != '0);
    ctl.interior = (row_r >= hse_pkg::CW'(2)) && (col_r != '0)
                   && (col_r != hse_pkg::CW'(hse_pkg::GRID_SIZE - 1));
    ctl.last = (row_r == hse_pkg::CW'(hse_pkg::GRID_SIZE - 1))
               && (col_r == hse_pkg::CW'(hse_pkg::GRID_SIZE - 1));
    unique case (st_r)
      hse_pkg::S_IDLE: begin
        if (acc) begin
          st_nxt = hse_pkg::S_READ;
          rd_en = 1'b1;
        end
      end
      hse_pkg::S_READ: begin
        st_nxt = hse_pkg::S_WAIT;
      end
      hse_pkg::S_WAIT: begin
        step = 1'b1;
        wr_en = 1'b1;
        st_nxt = hse_pkg::S_IDLE;
        if (col_r == hse_pkg::CW'(hse_pkg::GRID_SIZE - 1)) begin
          col_nxt = '0;
          row_nxt = (row_r == hse_pkg::CW'(hse_pkg::GRID_SIZE - 1)) ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      default: st_nxt = hse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hse_pkg::S_IDLE;
      col_r <= '0;
      row_r <= '0;
      kr_r <= -32'sd102400;
      kc_r <= -32'sd102400;
      area_r <= 24'd671089;
      out_busy_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hse_pkg::REG_COEF_ROWS: kr_r <= cfg_data;
          hse_pkg::REG_COEF_COLS: kc_r <= cfg_data;
          hse_pkg::REG_AREA: area_r <= cfg_data[hse_pkg::AREA_W-1:0];
          default: ;
        endcase
      end
      if (acc && row_r != '0) out_busy_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_busy_r <= 1'b0;
    end
    if (acc) begin
      down_r <= in_ch.psi_sample;
      pot_in_r <= in_ch.potential_value;
    end
    if (st_r == hse_pkg::S_READ) rctr_r <= rd_ctr;
    if (step) left_r <= rctr_r;
  end

  hse_datapath u_dp (
    .clk, .rst_n, .step, .ctl,
    .up(rd_up), .down(down_r), .left(left_r), .centre(rctr_r), .right,
    .pot(rd_pot), .coef_rows(kr_r), .coef_cols(kc_r), .area(area_r),
    .done, .hpsi, .last(lst), .energy(en)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_ch.valid <= 1'b0;
    else if (done) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
    if (done) begin
      out_ch.hpsi_value <= hpsi;
      out_ch.frame_last <= lst;
      out_ch.energy_total <= en;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hse_linebuf.sv -----
// Line buffers: psi rows r-2 and r-1 and potential row r-1, read then rewritten.
`default_nettype none
module hse_linebuf (
  input  wire logic clk,
  input  wire logic rd_en,
  input  wire logic [hse_pkg::CW-1:0] rd_addr,
  input  wire logic wr_en,
  input  wire logic [hse_pkg::CW-1:0] wr_addr,
  input  wire logic signed [hse_pkg::PSI_W-1:0] wr_up,
  input  wire logic signed [hse_pkg::PSI_W-1:0] wr_ctr,
  input  wire logic [hse_pkg::POT_W-1:0] wr_pot,
  output logic signed [hse_pkg::PSI_W-1:0] rd_up,
  output logic signed [hse_pkg::PSI_W-1:0] rd_ctr,
  output logic [hse_pkg::POT_W-1:0] rd_pot
);
  logic [hse_pkg::PSI_W-1:0] up_mem [hse_pkg::GRID_SIZE];
  logic [hse_pkg::PSI_W-1:0] ctr_mem [hse_pkg::GRID_SIZE];
  logic [hse_pkg::POT_W-1:0] pot_mem [hse_pkg::GRID_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      up_mem[wr_addr] <= wr_up;
      ctr_mem[wr_addr] <= wr_ctr;
      pot_mem[wr_addr] <= wr_pot;
    end
    if (rd_en) begin
      rd_up <= up_mem[rd_addr];
      rd_ctr <= ctr_mem[rd_addr];
      rd_pot <= pot_mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hse_datapath.sv -----
// Arithmetic pipeline: stencil products, H*psi saturation, energy term and accumulator.
`default_nettype none
module hse_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire hse_pkg::ctl_t ctl,
  input  wire logic signed [hse_pkg::PSI_W-1:0] up,
  input  wire logic signed [hse_pkg::PSI_W-1:0] down,
  input  wire logic signed [hse_pkg::PSI_W-1:0] left,
  input  wire logic signed [hse_pkg::PSI_W-1:0] centre,
  input  wire logic signed [hse_pkg::PSI_W-1:0] right,
  input  wire logic [hse_pkg::POT_W-1:0] pot,
  input  wire logic signed [hse_pkg::COEF_W-1:0] coef_rows,
  input  wire logic signed [hse_pkg::COEF_W-1:0] coef_cols,
  input  wire logic [hse_pkg::AREA_W-1:0] area,
  output logic done,
  output logic signed [hse_pkg::HPSI_W-1:0] hpsi,
  output logic last,
  output logic signed [hse_pkg::EN_W-1:0] energy
);
  // stage 1: products
  logic signed [60:0] pr_r, pc_r, pp_r;
  logic signed [hse_pkg::PSI_W-1:0] c1_r;
  hse_pkg::ctl_t k1_r, k2_r, k3_r, k4_r;
  // stage 2: hpsi
  logic signed [hse_pkg::HPSI_W-1:0] h2_r;
  logic signed [hse_pkg::PSI_W-1:0] c2_r;
  // stage 3: psi*hpsi
  logic signed [hse_pkg::HPSI_W-1:0] h3_r;
  logic signed [33:0] t3_r;
  // stage 4: times area
  logic signed [hse_pkg::HPSI_W-1:0] h4_r;
  logic signed [39:0] t4_r;
  logic signed [hse_pkg::EN_W-1:0] acc_r, acc_nxt;

  logic signed [25:0] lap_r, lap_c;
  logic signed [62:0] sum;
  logic signed [42:0] shs;
  logic signed [hse_pkg::HPSI_W-1:0] hsat;
  logic signed [55:0] ch;
  logic signed [58:0] ta;
  logic signed [hse_pkg::EN_W:0] asum;

  always_comb begin
    lap_r = 26'(up) + 26'(down) - 26'(centre) - 26'(centre);
    lap_c = 26'(left) + 26'(right) - 26'(centre) - 26'(centre);
    sum = 63'(pr_r) + 63'(pc_r) + 63'(pp_r);
    shs = 43'(sum >>> 20);
    if (shs > 43'sd2147483647) hsat = 32'sh7fffffff;
    else if (shs < -43'sd2147483648) hsat = 32'sh80000000;
    else hsat = shs[31:0];
    ch = 56'(c2_r) * 56'(h2_r);
    ta = 59'(t3_r) * $signed({35'd0, area});
    asum = 49'(acc_r) + 49'(t4_r);
    acc_nxt = acc_r;
    if (k4_r.valid && k4_r.interior) begin
      if (asum > 49'sh0_7fff_ffff_ffff) acc_nxt = 48'sh7fff_ffff_ffff;
      else if (asum < -49'sh0_8000_0000_0000) acc_nxt = 48'sh8000_0000_0000;
      else acc_nxt = asum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= '0; k2_r <= '0; k3_r <= '0; k4_r <= '0;
      acc_r <= '0; done <= 1'b0;
    end else begin
      k1_r <= step ? ctl : '0;
      k2_r <= k1_r; k3_r <= k2_r; k4_r <= k3_r;
      done <= k4_r.valid;
      if (k4_r.valid && k4_r.last) acc_r <= '0;
      else acc_r <= acc_nxt;
      last <= k4_r.last;
      energy <= k4_r.last ? acc_nxt : '0;
      hpsi <= h4_r;
    end
    pr_r <= 61'(coef_rows * 58'(lap_r)) <<< 4;
    pc_r <= 61'(coef_cols * 58'(lap_c)) <<< 4;
    pp_r <= 61'($signed({1'b0, pot}) * centre);
    c1_r <= centre;
    h2_r <= k1_r.interior ? hsat : '0;
    c2_r <= c1_r;
    h3_r <= h2_r;
    t3_r <= 34'(ch >>> 22);
    h4_r <= h3_r;
    t4_r <= 40'(ta >>> 20);
  end
endmodule
`default_nettype wire

// ----- rtl/hse_checker.sv -----
// Port checker for the stencil block, bound to the top level.
`default_nettype none
module hse_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic frame_last,
  input wire logic [47:0] energy_total
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("accept while result pending");
  a_energy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_last |-> energy_total == '0) else $error("energy off frame end");
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule

bind hamiltonian_stencil_energy hse_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .frame_last(out_ch.frame_last), .energy_total(out_ch.energy_total)
);
`default_nettype wire

// ----- sim/tb_hamiltonian_stencil_energy.sv -----
// Testbench: streams grid samples through the stencil block and checks every result.
module tb_hamiltonian_stencil_energy;

  typedef struct {
    logic signed [hse_pkg::PSI_W-1:0] psi;
    logic [hse_pkg::POT_W-1:0]        pot;
  } sample_t;

  typedef struct {
    logic signed [hse_pkg::HPSI_W-1:0] hpsi;
    logic                              last;
    logic signed [hse_pkg::EN_W-1:0]   energy;
  } hpsi_res_t;

  localparam longint ENERGY_MAX = 64'sd140737488355327;
  localparam longint ENERGY_MIN = -ENERGY_MAX - 1;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 119;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [hse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hse_pkg::COEF_W-1:0] cfg_data = '0;

  hse_in_if in_ch();
  hse_out_if out_ch();

  hamiltonian_stencil_energy i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  longint coef_rows, coef_cols, area;
  logic signed [hse_pkg::PSI_W-1:0] psi_above [hse_pkg::GRID_SIZE];
  logic signed [hse_pkg::PSI_W-1:0] psi_centre [hse_pkg::GRID_SIZE];
  logic [hse_pkg::POT_W-1:0] pot_centre [hse_pkg::GRID_SIZE];
  logic signed [hse_pkg::PSI_W-1:0] psi_left;
  int grid_row, grid_col;
  longint energy_sum;

  sample_t pending_q[$];
  hpsi_res_t hpsi_expected_q[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  logic hold_kick = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_saturated = 0;
  longint cycles = 0;

  task automatic apply_hamiltonian(input logic signed [hse_pkg::PSI_W-1:0] down,
                                   input logic [hse_pkg::POT_W-1:0] pot_in);
    longint centre, up, left, right, pot, lap_r, lap_c, acc, hpsi, term;
    hpsi_res_t res;
    logic last, interior;
    if (grid_row >= 1) begin
      centre = psi_centre[grid_col];
      up = psi_above[grid_col];
      left = psi_left;
      right = (grid_col + 1 < hse_pkg::GRID_SIZE) ? longint'(psi_centre[grid_col + 1]) : 0;
      pot = longint'({1'b0, pot_centre[grid_col]});
      hpsi = 0;
      last = (grid_row == hse_pkg::GRID_SIZE - 1) && (grid_col == hse_pkg::GRID_SIZE - 1);
      interior = (grid_row >= 2) && (grid_col >= 1) && (grid_col + 1 < hse_pkg::GRID_SIZE);
      if (interior) begin
        lap_r = up + longint'(down) - 2 * centre;
        lap_c = left + right - 2 * centre;
        acc = coef_rows * lap_r * 16 + coef_cols * lap_c * 16 + pot * centre;
        hpsi = acc >>> 20;
        if (hpsi > 64'sd2147483647 || hpsi < -64'sd2147483648) n_saturated++;
        if (hpsi > 64'sd2147483647) hpsi = 64'sd2147483647;
        if (hpsi < -64'sd2147483648) hpsi = -64'sd2147483648;
        term = (centre * hpsi) >>> 22;
        term = (term * area) >>> 20;
        energy_sum = energy_sum + term;
        if (energy_sum > ENERGY_MAX) energy_sum = ENERGY_MAX;
        if (energy_sum < ENERGY_MIN) energy_sum = ENERGY_MIN;
      end
      res.hpsi = hpsi[hse_pkg::HPSI_W-1:0];
      res.last = last;
      res.energy = last ? energy_sum[hse_pkg::EN_W-1:0] : '0;
      if (last) begin
        energy_sum = 0;
        n_frames++;
      end
      hpsi_expected_q.push_back(res);
    end
    psi_left = psi_centre[grid_col];
    psi_above[grid_col] = psi_centre[grid_col];
    psi_centre[grid_col] = down;
    pot_centre[grid_col] = pot_in;
    if (grid_col + 1 >= hse_pkg::GRID_SIZE) begin
      grid_col = 0;
      grid_row = (grid_row + 1 >= hse_pkg::GRID_SIZE) ? 0 : grid_row + 1;
    end else begin
      grid_col = grid_col + 1;
    end
  endtask

  task automatic cfg_write(input logic [hse_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hse_pkg::COEF_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      hse_pkg::REG_COEF_ROWS: coef_rows = longint'($signed(val));
      hse_pkg::REG_COEF_COLS: coef_cols = longint'($signed(val));
      hse_pkg::REG_AREA: area = longint'({40'd0, val[hse_pkg::AREA_W-1:0]});
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] rand_field(input bit smooth);
    logic [23:0] v;
    v = 24'($urandom);
    if (smooth) v = {{5{v[19]}}, v[18:0]};
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_hamiltonian(in_ch.psi_sample, in_ch.potential_value);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.psi_sample <= s.psi;
          in_ch.potential_value <= s.pot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk) begin
    hpsi_res_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (hpsi_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result hpsi=%0d last=%0b energy=%0d",
                     out_ch.hpsi_value, out_ch.frame_last, out_ch.energy_total);
        end else begin
          exp_r = hpsi_expected_q.pop_front();
          if (out_ch.hpsi_value !== exp_r.hpsi || out_ch.frame_last !== exp_r.last ||
              out_ch.energy_total !== exp_r.energy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: hpsi %0d/%0d last %0b/%0b energy %0d/%0d (exp/got)",
                       n_results, exp_r.hpsi, out_ch.hpsi_value, exp_r.last,
                       out_ch.frame_last, exp_r.energy, out_ch.energy_total);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sample_t s;
    int mode;
    in_ch.valid = 1'b0;
    in_ch.psi_sample = '0;
    in_ch.potential_value = '0;
    out_ch.ready = 1'b0;
    coef_rows = -102400;
    coef_cols = -102400;
    area = 671089;
    psi_left = '0;
    grid_row = 0;
    grid_col = 0;
    energy_sum = 0;
    for (int i = 0; i < hse_pkg::GRID_SIZE; i++) begin
      psi_above[i] = '0;
      psi_centre[i] = '0;
      pot_centre[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          cfg_write(hse_pkg::REG_COEF_ROWS, 32'h7fffffff);
          cfg_write(hse_pkg::REG_COEF_COLS, 32'h80000000);
          cfg_write(hse_pkg::REG_AREA, 32'h00ffffff);
        end
        2: begin
          cfg_write(hse_pkg::REG_COEF_ROWS, 32'h0);
          cfg_write(hse_pkg::REG_COEF_COLS, 32'h0);
          cfg_write(hse_pkg::REG_AREA, 32'h0);
        end
        3: begin
          cfg_write(hse_pkg::REG_COEF_ROWS, 32'h80000000);
          cfg_write(hse_pkg::REG_COEF_COLS, 32'h7fffffff);
          cfg_write(hse_pkg::REG_AREA, 32'hff100000);
        end
        4, 5, 6: begin
          cfg_write(hse_pkg::REG_COEF_ROWS,
                    $urandom_range(1, 0) ? $urandom : -$urandom_range(300000));
          cfg_write(hse_pkg::REG_COEF_COLS, -$urandom_range(300000));
          cfg_write(hse_pkg::REG_AREA, $urandom);
        end
        7: begin
          cfg_write(hse_pkg::REG_COEF_ROWS, -32'sd102400);
          cfg_write(hse_pkg::REG_COEF_COLS, -32'sd102400);
          cfg_write(hse_pkg::REG_AREA, 32'd671089);
        end
        default: ;
      endcase
      mode = ph % 4;
      src_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 55 : 25) : 0;
      sink_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 55 : 25) : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i < 24) begin
          case (i % 6)
            0: begin s.psi = 24'h7fffff; s.pot = 24'hffffff; end
            1: begin s.psi = 24'h800000; s.pot = 24'h000000; end
            2: begin s.psi = 24'h000000; s.pot = 24'hffffff; end
            3: begin s.psi = 24'hffffff; s.pot = 24'h800000; end
            4: begin s.psi = 24'h7fffff; s.pot = 24'h000001; end
            default: begin s.psi = 24'h800000; s.pot = 24'hffffff; end
          endcase
        end else begin
          s.psi = rand_field($urandom_range(99) < 70);
          s.pot = rand_field($urandom_range(99) < 70) & 24'hffffff;
        end
        pending_q.push_back(s);
      end
      if (ph == 2) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      while (pending_q.size() != 0 || in_ch.valid || hpsi_expected_q.size() != 0)
        @(posedge clk);
      repeat (12) @(posedge clk);
    end

    $display("covered %0d items over %0d frames, %0d results checked, %0d saturated",
             n_accepted, n_frames, n_results, n_saturated);
    $display("register settings swept through extremes under four idle patterns");
    if (mismatches == 0 && hpsi_expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, hpsi_expected_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
